>>> rtl/core/sstins_pkg.sv
// Shared types and codes for the sorted seed table.
package sstins_pkg;

   // operation codes on req_func
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_CONTAINED = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_READ_OK   = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   // read address sources for the table memory
   localparam logic [2:0] RD_FIRST = 3'd0;   // entry zero, start of a scan
   localparam logic [2:0] RD_INDEX = 3'd1;   // requested index
   localparam logic [2:0] RD_SCAN  = 3'd2;   // entry after the one under test
   localparam logic [2:0] RD_TOP   = 3'd3;   // last occupied entry
   localparam logic [2:0] RD_SHIFT = 3'd4;   // source of the next shift move

   localparam int TOTAL_W = 7;
   localparam int INDEX_W = 6;

   typedef struct packed {
      logic [15:0] chrom;
      logic [15:0] read_first;
      logic [15:0] read_last;
      logic [31:0] genome_first;
      logic [31:0] genome_last;
   } sstins_entry_type;

   typedef struct packed {
      logic       latch;       // capture request fields
      logic [2:0] rd_sel;      // table read address source
      logic       scan_adv;    // advance the scan pointer
      logic       sh_init;     // load the shift pointer with the count
      logic       sh_step;     // move one entry up, step the pointer down
      logic       put_seed;    // write the new seed, bump the count
      logic       cnt_clr;     // empty the table
      logic       rsp_fire;    // emit one result beat
      logic [2:0] rsp_st;
      logic       rsp_data;    // result carries the entry read
   } sstins_cmd_type;

   typedef struct packed {
      logic scan_done;   // scan pointer reached the count
      logic scan_stop;   // entry under test sorts above the new seed
      logic scan_hit;    // entry under test contains the new seed
      logic full;
      logic sh_at_pos;   // shift pointer reached the insertion point
      logic idx_ok;      // requested index is occupied
   } sstins_stat_type;

endpackage

>>> rtl/core/sstins_ctrl.sv
// Operation sequencer for the sorted seed table.
module sstins_ctrl
   import sstins_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      req_func,
   input  sstins_stat_type stat,
   output sstins_cmd_type  cmd,
   output logic            busy
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_PREP  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_FIRST;
      unique case (state_ff)
         S_IDLE: begin
            cmd.rd_sel = (req_func == FUNC_INSERT) ? RD_FIRST : RD_INDEX;
            if (start) begin
               cmd.latch = 1'b1;
               case (req_func)
                  FUNC_INSERT: state_in = S_SCAN;
                  FUNC_CLEAR: begin
                     cmd.cnt_clr  = 1'b1;
                     cmd.rsp_fire = 1'b1;
                     cmd.rsp_st   = ST_CLEARED;
                  end
                  default: state_in = S_READ;
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_fire = 1'b1;
            cmd.rsp_data = stat.idx_ok;
            cmd.rsp_st   = stat.idx_ok ? ST_READ_OK : ST_EMPTY;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            cmd.rd_sel = RD_SCAN;
            if (stat.scan_done || stat.scan_stop) begin
               if (stat.full) begin
                  cmd.rsp_fire = 1'b1;
                  cmd.rsp_st   = ST_FULL;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_PREP;
               end
            end else if (stat.scan_hit) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_st   = ST_CONTAINED;
               state_in     = S_IDLE;
            end else begin
               cmd.scan_adv = 1'b1;
            end
         end
         S_PREP: begin
            cmd.rd_sel  = RD_TOP;
            cmd.sh_init = 1'b1;
            state_in    = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.rd_sel = RD_SHIFT;
            if (stat.sh_at_pos) begin
               cmd.put_seed = 1'b1;
               cmd.rsp_fire = 1'b1;
               cmd.rsp_st   = ST_INSERTED;
               state_in     = S_IDLE;
            end else begin
               cmd.sh_step = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> rtl/core/sstins_dpath.sv
// Table memory, pointers, count and result register of the seed table.
module sstins_dpath
   import sstins_pkg::*;
#(
   parameter int MAX_SEEDS = 64
)
(
   input  logic                clock,
   input  logic                reset,
   input  sstins_cmd_type      cmd,
   output sstins_stat_type     stat,
   input  logic [15:0]         req_chrom_id,
   input  logic [15:0]         req_read_first,
   input  logic [15:0]         req_read_last,
   input  logic [31:0]         req_genome_first,
   input  logic [31:0]         req_genome_last,
   input  logic [INDEX_W-1:0]  req_entry_index,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [TOTAL_W-1:0]  rsp_seed_total,
   output sstins_entry_type    rsp_entry
);

   localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CW = $clog2(MAX_SEEDS + 1);
   localparam int XW = (CW > TOTAL_W) ? CW : TOTAL_W;

   sstins_entry_type mem [MAX_SEEDS];
   sstins_entry_type rd_data_ff;
   sstins_entry_type seed_ff;
   sstins_entry_type wr_data;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             wr_en;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, sh_ff;
   logic [CW-1:0] pos_nxt, cnt_dec, sh_dec2;
   logic [INDEX_W-1:0] idx_ff;
   logic [XW-1:0] idx_ext, req_idx_ext, tot_ext;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   sstins_entry_type rsp_entry_ff;

   assign pos_nxt     = pos_ff + CW'(1);
   assign cnt_dec     = count_ff - CW'(1);
   assign sh_dec2     = sh_ff - CW'(2);
   assign req_idx_ext = XW'(req_entry_index);
   assign idx_ext     = XW'(idx_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_INDEX: rd_addr = req_idx_ext[AW-1:0];
         RD_SCAN:  rd_addr = pos_nxt[AW-1:0];
         RD_TOP:   rd_addr = cnt_dec[AW-1:0];
         RD_SHIFT: rd_addr = sh_dec2[AW-1:0];
         default:  rd_addr = '0;
      endcase
   end

   // shift moves copy the entry just read one place up; the final write drops in the seed
   assign wr_en   = cmd.sh_step || cmd.put_seed;
   assign wr_addr = cmd.put_seed ? pos_ff[AW-1:0] : sh_ff[AW-1:0];
   assign wr_data = cmd.put_seed ? seed_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // rd_data_ff holds the entry at pos_ff during a scan
   always_comb begin
      stat.scan_done = (pos_ff == count_ff);
      stat.scan_stop = (rd_data_ff.chrom > seed_ff.chrom) ||
                       ((rd_data_ff.chrom == seed_ff.chrom) &&
                        (rd_data_ff.genome_first > seed_ff.genome_first));
      stat.scan_hit  = (rd_data_ff.chrom == seed_ff.chrom) &&
                       (rd_data_ff.read_first <= seed_ff.read_first) &&
                       (rd_data_ff.read_last >= seed_ff.read_last) &&
                       (rd_data_ff.genome_first <= seed_ff.genome_first) &&
                       (rd_data_ff.genome_last >= seed_ff.genome_last);
      stat.full      = (count_ff == CW'(MAX_SEEDS));
      stat.sh_at_pos = (sh_ff == pos_ff);
      stat.idx_ok    = (idx_ext < XW'(count_ff));
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.put_seed) begin
         count_in = count_ff + CW'(1);
      end
   end
   assign tot_ext = XW'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         seed_ff.chrom        <= req_chrom_id;
         seed_ff.read_first   <= req_read_first;
         seed_ff.read_last    <= req_read_last;
         seed_ff.genome_first <= req_genome_first;
         seed_ff.genome_last  <= req_genome_last;
         idx_ff               <= req_entry_index;
      end
      if (cmd.rsp_fire) begin
         rsp_status_ff <= cmd.rsp_st;
         rsp_total_ff  <= tot_ext[TOTAL_W-1:0];
         rsp_entry_ff  <= cmd.rsp_data ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         sh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_fire;
         if (cmd.latch) begin
            pos_ff <= '0;
         end else if (cmd.scan_adv) begin
            pos_ff <= pos_nxt;
         end
         if (cmd.sh_init) begin
            sh_ff <= count_ff;
         end else if (cmd.sh_step) begin
            sh_ff <= sh_ff - CW'(1);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_seed_total = rsp_total_ff;
   assign rsp_entry      = rsp_entry_ff;

   a_put_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.put_seed |-> (count_ff < CW'(MAX_SEEDS)))
      else $error("seed written into a full table");

   a_put_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.put_seed |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("count did not advance after an insert");

   a_shift_above_pos: assert property (@(posedge clock) disable iff (reset)
      cmd.sh_step |-> (sh_ff > pos_ff))
      else $error("shift moved an entry below the insertion point");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_adv |-> (pos_ff < count_ff))
      else $error("scan advanced past the occupied entries");

endmodule

>>> rtl/core/sorted_seed_table_insert_top.sv
// Top level of the sorted seed table with containment filter.
//
//   channel   ports                         handshake
//   -------   ---------------------------   ----------------------------------
//   request   start, busy, req_*            beat taken when start && !busy
//   result    rsp_valid, rsp_*              one-cycle strobe, always taken
//
// Sequence: a clear is done without raising busy; a read holds busy in S_READ.
// An insert into a table of n seeds walks the k entries ahead of its slot one
// per cycle, then moves the n - k later entries up one per cycle in S_SHIFT;
// a contained seed or a full table ends it after the walk. The table memory, one
// registered read and one write per cycle, limits both to one entry per cycle.
// The strobe rises the cycle after the last busy cycle, or after a clear's start.
// Reset is synchronous; it empties the table (count to zero) and idles the
// sequencer. Table contents are not cleared; entries at or above the count are
// never returned in a result. The receiver cannot stall, so results never back up.
module sorted_seed_table_insert_top
   import sstins_pkg::*;
#(
   parameter int MAX_SEEDS = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_func,
   input  logic [15:0]  req_chrom_id,
   input  logic [15:0]  req_read_first,
   input  logic [15:0]  req_read_last,
   input  logic [31:0]  req_genome_first,
   input  logic [31:0]  req_genome_last,
   input  logic [5:0]   req_entry_index,
   output logic         rsp_valid,
   output logic [2:0]   rsp_status,
   output logic [6:0]   rsp_seed_total,
   output logic [15:0]  rsp_out_chrom,
   output logic [15:0]  rsp_out_read_first,
   output logic [15:0]  rsp_out_read_last,
   output logic [31:0]  rsp_out_genome_first,
   output logic [31:0]  rsp_out_genome_last
);

   sstins_cmd_type   cmd;
   sstins_stat_type  stat;
   sstins_entry_type rsp_entry;

   // sequencer: decodes the beat, drives scan, shift and result commands
   sstins_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // datapath: table memory, scan and shift pointers, seed count, result beat
   sstins_dpath #(
      .MAX_SEEDS (MAX_SEEDS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_chrom_id     (req_chrom_id),
      .req_read_first   (req_read_first),
      .req_read_last    (req_read_last),
      .req_genome_first (req_genome_first),
      .req_genome_last  (req_genome_last),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_seed_total   (rsp_seed_total),
      .rsp_entry        (rsp_entry)
   );

   // split the registered entry onto its result ports
   assign rsp_out_chrom        = rsp_entry.chrom;
   assign rsp_out_read_first   = rsp_entry.read_first;
   assign rsp_out_read_last    = rsp_entry.read_last;
   assign rsp_out_genome_first = rsp_entry.genome_first;
   assign rsp_out_genome_last  = rsp_entry.genome_last;

endmodule
